// ===== rtl/sss_pkg.sv =====
// sss_pkg: shared types, constants and helpers for the stimulation segment sequencer
// no dependencies; used by sss_front, sss_queue, sss_back and stim_segment_sequencer
package sss_pkg;

    localparam int SEGMENTS_DEF = 16;   // default segment table size
    localparam int QDEPTH       = 4;    // entries between front and back
    localparam int SEGW         = 5;    // width of the segment counter
    localparam int PADDR_W      = 5;
    localparam int PDATA_W      = 32;

    // stimulator register addresses
    localparam logic [6:0] ADDR_STIM_ON     = 7'd42;
    localparam logic [6:0] ADDR_STIM_POL    = 7'd44;
    localparam logic [6:0] ADDR_POS_BASE    = 7'd96;
    localparam logic [6:0] ADDR_NEG_BASE    = 7'd64;
    localparam logic [6:0] ADDR_SETTLE_F_L  = 7'd12;
    localparam logic [6:0] ADDR_SETTLE_TRAD = 7'd10;
    localparam logic [6:0] ADDR_RECOV_EN    = 7'd48;
    localparam logic [6:0] ADDR_RECOV_SW    = 7'd46;

    // bit positions in the back end's change mask, in emission order
    localparam int CHG_ON     = 0;
    localparam int CHG_MAG    = 1;
    localparam int CHG_POL    = 2;
    localparam int CHG_SETTLE = 3;
    localparam int CHG_RECOV  = 4;
    localparam int NCHG       = 5;

    typedef enum logic [2:0] {
        REG_STIM_CHANNEL  = 3'd0,
        REG_LOOP_FIRST    = 3'd1,
        REG_LOOP_LAST     = 3'd2,
        REG_LOOP_COUNT    = 3'd3,
        REG_SEGMENT_TOTAL = 3'd4,
        REG_SETTLE_MODE   = 3'd5,
        REG_RECOVERY_MODE = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [3:0]        stim_channel;
        logic [3:0]        loop_first;
        logic [3:0]        loop_last;
        logic signed [8:0] loop_count;
        logic [4:0]        segment_total;
        logic              settle_mode;
        logic              recovery_mode;
    } cfg_t;

    // one segment application handed from front to back
    typedef struct packed {
        logic signed [8:0] mag;
        logic              settle;
        logic              recovery;
    } apply_t;

    function automatic logic [15:0] fix_len(input logic [15:0] len);
        return (len == 16'd0) ? 16'd1 : len;
    endfunction

endpackage

// ===== rtl/sss_front.sv =====
// sss_front: accepts items, holds the segment table and the run state,
// and pushes one segment application per active tick; depends on sss_pkg
module sss_front #(
    parameter int SEGMENTS = sss_pkg::SEGMENTS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sss_pkg::cfg_t         cfg,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_command,
    input  logic                  s_trigger,
    input  logic [3:0]            s_seg_index,
    input  logic [15:0]           s_seg_length,
    input  logic signed [8:0]     s_seg_magnitude,
    input  logic                  s_seg_settle,
    input  logic                  s_seg_recovery,
    output logic                  q_push,
    output sss_pkg::apply_t       q_data,
    input  logic                  q_ready
);

    // only indices below 16 can ever be loaded
    localparam int DEPTH = (SEGMENTS < 16) ? SEGMENTS : 16;
    localparam int IDXW  = $clog2(DEPTH);
    localparam logic [sss_pkg::SEGW-1:0] SEG_LIMIT = sss_pkg::SEGW'(DEPTH);

    logic [15:0]       len_tbl_reg [DEPTH];
    logic signed [8:0] mag_tbl_reg [DEPTH];
    logic [1:0]        flag_tbl_reg[DEPTH];

    logic                      running_reg, running_next;
    logic                      pending_reg, pending_next;
    logic [sss_pkg::SEGW-1:0]  cur_reg, cur_next;
    logic [15:0]               ticks_reg, ticks_next;
    logic signed [8:0]         rep_reg, rep_next;

    logic                      accept, tick_go, load_go, pend;
    logic                      e_run;
    logic [sss_pkg::SEGW-1:0]  e_cur, cur_plus, step, nxt, apply_idx;
    logic [15:0]               e_ticks, len_first, len_nxt;
    logic signed [8:0]         e_rep;
    logic                      apply_ok;

    assign s_ready = q_ready;
    assign accept  = s_valid && s_ready;
    assign tick_go = accept && !s_command;
    assign load_go = accept && s_command;

    assign len_first = sss_pkg::fix_len(len_tbl_reg[IDXW'(1)]);
    assign len_nxt   = (nxt < SEG_LIMIT) ? sss_pkg::fix_len(len_tbl_reg[nxt[IDXW-1:0]]) : 16'd1;

    always_comb begin
        pend       = pending_reg | s_trigger;
        e_run      = running_reg;
        e_cur      = cur_reg;
        e_ticks    = ticks_reg;
        e_rep      = rep_reg;
        if (!running_reg && pend) begin
            e_run   = 1'b1;
            e_cur   = sss_pkg::SEGW'(1);
            e_ticks = len_first;
            e_rep   = cfg.loop_count;
        end
        cur_plus = e_cur + sss_pkg::SEGW'(1);
        if (e_cur == {1'b0, cfg.loop_last} && e_rep != 9'sd0) begin
            step = {1'b0, cfg.loop_first};
        end else begin
            step = cur_plus;
        end
        nxt = (step == cfg.segment_total) ? '0 : step;
    end

    always_comb begin
        running_next = running_reg;
        pending_next = pending_reg;
        cur_next     = cur_reg;
        ticks_next   = ticks_reg;
        rep_next     = rep_reg;
        q_push       = 1'b0;
        apply_idx    = e_cur;
        if (tick_go) begin
            pending_next = pend && running_reg;
            if (e_run) begin
                q_push = 1'b1;
                if (e_cur == '0) begin
                    // rest segment: last tick of a run
                    running_next = 1'b0;
                end else begin
                    running_next = 1'b1;
                    if (e_ticks > 16'd1) begin
                        cur_next   = e_cur;
                        ticks_next = e_ticks - 16'd1;
                        rep_next   = e_rep;
                    end else begin
                        cur_next   = nxt;
                        ticks_next = len_nxt;
                        // negative count loops forever
                        if (e_cur == {1'b0, cfg.loop_last} && e_rep != 9'sd0 && !e_rep[8]) begin
                            rep_next = e_rep - 9'sd1;
                        end else begin
                            rep_next = e_rep;
                        end
                    end
                end
            end
        end
    end

    assign apply_ok = apply_idx < SEG_LIMIT;

    always_comb begin
        q_data.mag      = apply_ok ? mag_tbl_reg[apply_idx[IDXW-1:0]] : 9'sd0;
        q_data.settle   = apply_ok ? flag_tbl_reg[apply_idx[IDXW-1:0]][0] : 1'b0;
        q_data.recovery = apply_ok ? flag_tbl_reg[apply_idx[IDXW-1:0]][1] : 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (load_go && ({1'b0, s_seg_index} < SEG_LIMIT)) begin
            len_tbl_reg[s_seg_index[IDXW-1:0]]  <= s_seg_length;
            mag_tbl_reg[s_seg_index[IDXW-1:0]]  <= s_seg_magnitude;
            flag_tbl_reg[s_seg_index[IDXW-1:0]] <= {s_seg_recovery, s_seg_settle};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            pending_reg <= 1'b0;
            cur_reg     <= '0;
            ticks_reg   <= '0;
            rep_reg     <= '0;
        end else begin
            running_reg <= running_next;
            pending_reg <= pending_next;
            cur_reg     <= cur_next;
            ticks_reg   <= ticks_next;
            rep_reg     <= rep_next;
        end
    end

endmodule

// ===== rtl/sss_queue.sv =====
// sss_queue: short first-in first-out buffer of segment applications
// depends on sss_pkg for the entry type
module sss_queue #(
    parameter int DEPTH = sss_pkg::QDEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  sss_pkg::apply_t  push_data,
    output logic             push_ready,
    input  logic             pop,
    output sss_pkg::apply_t  pop_data,
    output logic             pop_valid
);

    localparam int PW = $clog2(DEPTH);

    sss_pkg::apply_t     q_mem_reg [DEPTH];
    logic [PW-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]         count_reg;
    logic                do_push, do_pop;

    assign push_ready = count_reg < (PW+1)'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = q_mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            q_mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + (PW+1)'(1);
            end else if (!do_push && do_pop) begin
                count_reg <= count_reg - (PW+1)'(1);
            end
        end
    end

endmodule

// ===== rtl/sss_back.sv =====
// sss_back: compares each segment application with the shadow registers
// and emits one register write per change; depends on sss_pkg
module sss_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  sss_pkg::cfg_t    cfg,
    input  logic             q_valid,
    input  sss_pkg::apply_t  q_data,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [6:0]       m_reg_addr,
    output logic [7:0]       m_new_value,
    output logic             m_last_of_tick
);

    logic [sss_pkg::NCHG-1:0] mask_reg, mask_next, mask_after, new_mask, pick;
    logic       on_val_reg, pol_val_reg, fs_val_reg, cr_val_reg;
    logic [7:0] mag_val_reg;

    logic sh_on_reg, sh_pol_reg, sh_settle_reg, sh_recov_reg;
    logic [7:0] sh_pos_reg, sh_neg_reg;

    logic       m_valid_reg;
    logic [6:0] m_addr_reg, m_addr_next;
    logic [7:0] m_val_reg, m_val_next;
    logic       m_last_reg;

    logic       out_free, emit, load;
    logic       magzero, pol;
    logic [8:0] negm;
    logic [7:0] m;

    assign m_valid        = m_valid_reg;
    assign m_reg_addr     = m_addr_reg;
    assign m_new_value    = m_val_reg;
    assign m_last_of_tick = m_last_reg;

    assign out_free   = !m_valid_reg || m_ready;
    assign emit       = out_free && (mask_reg != '0);
    assign pick       = mask_reg & (~mask_reg + sss_pkg::NCHG'(1));   // lowest pending change
    assign mask_after = emit ? (mask_reg & ~pick) : mask_reg;
    assign q_pop      = q_valid && (mask_after == '0);
    assign load       = q_pop;

    // absolute magnitude, -256 saturates
    assign magzero = q_data.mag == 9'sd0;
    assign pol     = !q_data.mag[8] && !magzero;
    assign negm    = 9'd0 - q_data.mag;
    assign m       = q_data.mag[8] ? (negm[8] ? 8'hFF : negm[7:0]) : q_data.mag[7:0];

    always_comb begin
        new_mask = '0;
        new_mask[sss_pkg::CHG_ON]     = magzero ? sh_on_reg : !sh_on_reg;
        new_mask[sss_pkg::CHG_MAG]    = !magzero && (pol ? (sh_pos_reg != m) : (sh_neg_reg != m));
        new_mask[sss_pkg::CHG_POL]    = !magzero && (sh_pol_reg != pol);
        new_mask[sss_pkg::CHG_SETTLE] = sh_settle_reg != q_data.settle;
        new_mask[sss_pkg::CHG_RECOV]  = sh_recov_reg != q_data.recovery;
        mask_next = load ? new_mask : mask_after;
    end

    always_comb begin
        m_addr_next = sss_pkg::ADDR_STIM_ON;
        m_val_next  = {7'd0, on_val_reg};
        if (pick[sss_pkg::CHG_MAG]) begin
            m_addr_next = (pol_val_reg ? sss_pkg::ADDR_POS_BASE : sss_pkg::ADDR_NEG_BASE)
                          + {3'd0, cfg.stim_channel};
            m_val_next  = mag_val_reg;
        end else if (pick[sss_pkg::CHG_POL]) begin
            m_addr_next = sss_pkg::ADDR_STIM_POL;
            m_val_next  = {7'd0, pol_val_reg};
        end else if (pick[sss_pkg::CHG_SETTLE]) begin
            m_addr_next = cfg.settle_mode ? sss_pkg::ADDR_SETTLE_TRAD : sss_pkg::ADDR_SETTLE_F_L;
            m_val_next  = {7'd0, fs_val_reg};
        end else if (pick[sss_pkg::CHG_RECOV]) begin
            m_addr_next = cfg.recovery_mode ? sss_pkg::ADDR_RECOV_SW : sss_pkg::ADDR_RECOV_EN;
            m_val_next  = {7'd0, cr_val_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            on_val_reg  <= !magzero;
            pol_val_reg <= pol;
            mag_val_reg <= m;
            fs_val_reg  <= q_data.settle;
            cr_val_reg  <= q_data.recovery;
        end
        if (emit) begin
            m_addr_reg <= m_addr_next;
            m_val_reg  <= m_val_next;
            m_last_reg <= (mask_reg & ~pick) == '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg      <= '0;
            m_valid_reg   <= 1'b0;
            sh_on_reg     <= 1'b0;
            sh_pol_reg    <= 1'b0;
            sh_pos_reg    <= '0;
            sh_neg_reg    <= '0;
            sh_settle_reg <= 1'b0;
            sh_recov_reg  <= 1'b0;
        end else begin
            mask_reg <= mask_next;
            if (out_free) begin
                m_valid_reg <= emit;
            end
            // shadows track the stimulator as soon as the application is taken
            if (load) begin
                sh_on_reg     <= !magzero;
                sh_settle_reg <= q_data.settle;
                sh_recov_reg  <= q_data.recovery;
                if (!magzero) begin
                    sh_pol_reg <= pol;
                    if (pol) begin
                        sh_pos_reg <= m;
                    end else begin
                        sh_neg_reg <= m;
                    end
                end
            end
        end
    end

endmodule

// ===== rtl/stim_segment_sequencer.sv =====
// stim_segment_sequencer: top level with configuration registers, front, queue and back
// depends on sss_pkg, sss_front, sss_queue, sss_back
//
//  port group   dir     handshake            payload
//  s_*          in      s_valid / s_ready    command, trigger, segment table entry
//  m_*          out     m_valid / m_ready    reg_addr, new_value, last_of_tick
//  apb          in/out  psel+penable+pwrite  paddr[4:2] register index, pwdata
//
// the front completes each item in the cycle it is accepted; a tick that applies a segment queues it
// the back emits one write request per change and none for a tick with no change,
// so a tick yields up to five write requests there
// the first write request of a tick passes through the queue, the change mask and the output register
// the front stalls only when the four-entry queue is full
// reset is synchronous, active low; the segment table is not cleared and is
// undefined until loaded
module stim_segment_sequencer #(
    parameter int SEGMENTS = sss_pkg::SEGMENTS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sss_pkg::PADDR_W-1:0]  paddr,
    input  logic [sss_pkg::PDATA_W-1:0]  pwdata,
    output logic [sss_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_command,
    input  logic                         s_trigger,
    input  logic [3:0]                   s_seg_index,
    input  logic [15:0]                  s_seg_length,
    input  logic signed [8:0]            s_seg_magnitude,
    input  logic                         s_seg_settle,
    input  logic                         s_seg_recovery,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [6:0]                   m_reg_addr,
    output logic [7:0]                   m_new_value,
    output logic                         m_last_of_tick
);

    sss_pkg::cfg_t     cfg_reg;
    sss_pkg::cfg_idx_t cfg_idx;
    logic              cfg_wr;

    logic              q_push, q_ready, q_pop, q_valid;
    sss_pkg::apply_t   q_push_data, q_pop_data;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = sss_pkg::cfg_idx_t'(paddr[sss_pkg::PADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                sss_pkg::REG_STIM_CHANNEL:  cfg_reg.stim_channel  <= pwdata[3:0];
                sss_pkg::REG_LOOP_FIRST:    cfg_reg.loop_first    <= pwdata[3:0];
                sss_pkg::REG_LOOP_LAST:     cfg_reg.loop_last     <= pwdata[3:0];
                sss_pkg::REG_LOOP_COUNT:    cfg_reg.loop_count    <= pwdata[8:0];
                sss_pkg::REG_SEGMENT_TOTAL: cfg_reg.segment_total <= pwdata[4:0];
                sss_pkg::REG_SETTLE_MODE:   cfg_reg.settle_mode   <= pwdata[0];
                sss_pkg::REG_RECOVERY_MODE: cfg_reg.recovery_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            sss_pkg::REG_STIM_CHANNEL:  prdata = {28'd0, cfg_reg.stim_channel};
            sss_pkg::REG_LOOP_FIRST:    prdata = {28'd0, cfg_reg.loop_first};
            sss_pkg::REG_LOOP_LAST:     prdata = {28'd0, cfg_reg.loop_last};
            sss_pkg::REG_LOOP_COUNT:    prdata = {23'd0, cfg_reg.loop_count};
            sss_pkg::REG_SEGMENT_TOTAL: prdata = {27'd0, cfg_reg.segment_total};
            sss_pkg::REG_SETTLE_MODE:   prdata = {31'd0, cfg_reg.settle_mode};
            sss_pkg::REG_RECOVERY_MODE: prdata = {31'd0, cfg_reg.recovery_mode};
            default:                    prdata = '0;
        endcase
    end

    sss_front #(
        .SEGMENTS(SEGMENTS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_trigger       (s_trigger),
        .s_seg_index     (s_seg_index),
        .s_seg_length    (s_seg_length),
        .s_seg_magnitude (s_seg_magnitude),
        .s_seg_settle    (s_seg_settle),
        .s_seg_recovery  (s_seg_recovery),
        .q_push          (q_push),
        .q_data          (q_push_data),
        .q_ready         (q_ready)
    );

    sss_queue #(
        .DEPTH(sss_pkg::QDEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_push_data),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_data   (q_pop_data),
        .pop_valid  (q_valid)
    );

    sss_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .q_valid        (q_valid),
        .q_data         (q_pop_data),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_reg_addr     (m_reg_addr),
        .m_new_value    (m_new_value),
        .m_last_of_tick (m_last_of_tick)
    );

`ifndef SYNTH
    // a load transaction never queues a segment application
    a_load_no_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_command) |-> !q_push)
        else $error("load transaction pushed into queue");

    // the back end only pops when the queue holds an entry
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    // no result is offered in the cycle after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");
`endif

endmodule

// ===== test/stim_segment_sequencer_tb.sv =====
// stim_segment_sequencer_tb: self-checking bench for the stimulation segment sequencer
// drives segment loads and ticks, predicts the register write stream, checks every write
// depends on sss_pkg and the stim_segment_sequencer rtl
`timescale 1ns / 100ps

module stim_segment_sequencer_tb;

    localparam int SEG_N         = sss_pkg::SEGMENTS_DEF;
    localparam int RANDOM_ITEMS  = 343;
    localparam int PHASE_ITEMS   = 30;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;

    typedef enum bit {
        CMD_TICK = 1'b0,
        CMD_LOAD = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t              cmd;
        bit                trig;
        bit [3:0]          idx;
        bit [15:0]         len;
        logic signed [8:0] mag;
        bit                fs;
        bit                cr;
    } seg_item_t;

    typedef struct packed {
        logic [6:0] addr;
        logic [7:0] value;
        logic       last;
    } reg_write_t;

    typedef struct {
        seg_item_t it;
        int        typed_n;   // -1: take the predicted writes
    } script_row_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [sss_pkg::PADDR_W-1:0]     paddr = '0;
    logic [sss_pkg::PDATA_W-1:0]     pwdata = '0;
    logic [sss_pkg::PDATA_W-1:0]     prdata;
    logic                            pready;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic                            s_command = 1'b0;
    logic                            s_trigger = 1'b0;
    logic [3:0]                      s_seg_index = '0;
    logic [15:0]                     s_seg_length = '0;
    logic signed [8:0]               s_seg_magnitude = '0;
    logic                            s_seg_settle = 1'b0;
    logic                            s_seg_recovery = 1'b0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic [6:0]                      m_reg_addr;
    logic [7:0]                      m_new_value;
    logic                            m_last_of_tick;

    stim_segment_sequencer dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_trigger       (s_trigger),
        .s_seg_index     (s_seg_index),
        .s_seg_length    (s_seg_length),
        .s_seg_magnitude (s_seg_magnitude),
        .s_seg_settle    (s_seg_settle),
        .s_seg_recovery  (s_seg_recovery),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_reg_addr      (m_reg_addr),
        .m_new_value     (m_new_value),
        .m_last_of_tick  (m_last_of_tick)
    );

    always #5 aclk = ~aclk;

    int unsigned cycle_count = 0;
    int          errors = 0;
    int          ready_mode = 0;
    int          burst_left = 0;

    reg_write_t  reg_writes_due[$];   // register writes still owed by the block
    reg_write_t  tick_writes[$];      // writes caused by the transaction just accepted
    reg_write_t  typed_writes[$];     // hand-written writes for the directed rows
    script_row_t script[$];

    // predicted segment table and settings
    bit [15:0]         len_tab [SEG_N];
    logic signed [8:0] mag_tab [SEG_N];
    bit                fs_tab  [SEG_N];
    bit                cr_tab  [SEG_N];
    bit [3:0]          cfg_ch, cfg_loop_first, cfg_loop_last;
    logic signed [8:0] cfg_loop_count;
    bit [4:0]          cfg_seg_total;
    bit                cfg_settle_trad, cfg_recov_sw;

    // predicted run state and the stimulator shadow
    bit                run_active, start_waiting;
    bit [4:0]          cur_seg;
    bit [15:0]         seg_ticks_left;
    int                loops_left;
    bit                sh_on, sh_pol, sh_settle, sh_recov;
    bit [7:0]          sh_pos, sh_neg;

    function automatic bit [15:0] seg_ticks(bit [4:0] idx);
        if (idx >= SEG_N)
            return 16'd1;
        return (len_tab[idx[3:0]] == 16'd0) ? 16'd1 : len_tab[idx[3:0]];
    endfunction

    function automatic void note_write(logic [6:0] addr, logic [7:0] value);
        tick_writes.push_back(reg_write_t'{addr, value, 1'b0});
    endfunction

    function automatic void apply_seg(bit [4:0] idx);
        int       mag;
        int       amp;
        bit       fs, cr, pol;
        bit [7:0] m;
        mag = 0;
        fs = 1'b0;
        cr = 1'b0;
        // segments past the table behave as all-zero entries
        if (idx < SEG_N) begin
            mag = int'(mag_tab[idx[3:0]]);
            fs = fs_tab[idx[3:0]];
            cr = cr_tab[idx[3:0]];
        end
        if (mag == 0) begin
            if (sh_on) begin
                sh_on = 1'b0;
                note_write(sss_pkg::ADDR_STIM_ON, 8'd0);
            end
        end else begin
            amp = (mag < 0) ? -mag : mag;
            m = (amp > 255) ? 8'd255 : amp[7:0];
            pol = (mag > 0);
            if (!sh_on) begin
                sh_on = 1'b1;
                note_write(sss_pkg::ADDR_STIM_ON, 8'd1);
            end
            if (pol) begin
                if (sh_pos != m) begin
                    sh_pos = m;
                    note_write(sss_pkg::ADDR_POS_BASE + {3'b000, cfg_ch}, m);
                end
            end else if (sh_neg != m) begin
                sh_neg = m;
                note_write(sss_pkg::ADDR_NEG_BASE + {3'b000, cfg_ch}, m);
            end
            if (sh_pol != pol) begin
                sh_pol = pol;
                note_write(sss_pkg::ADDR_STIM_POL, {7'd0, pol});
            end
        end
        if (sh_settle != fs) begin
            sh_settle = fs;
            note_write(cfg_settle_trad ? sss_pkg::ADDR_SETTLE_TRAD : sss_pkg::ADDR_SETTLE_F_L,
                       {7'd0, fs});
        end
        if (sh_recov != cr) begin
            sh_recov = cr;
            note_write(cfg_recov_sw ? sss_pkg::ADDR_RECOV_SW : sss_pkg::ADDR_RECOV_EN,
                       {7'd0, cr});
        end
        if (tick_writes.size() > 0)
            tick_writes[tick_writes.size() - 1].last = 1'b1;
    endfunction

    function automatic void next_segment();
        if (!run_active)
            return;
        if (seg_ticks_left > 16'd1) begin
            seg_ticks_left = seg_ticks_left - 16'd1;
            return;
        end
        if (cur_seg == {1'b0, cfg_loop_last}) begin
            if (loops_left == 0) begin
                cur_seg = cur_seg + 5'd1;
            end else begin
                cur_seg = {1'b0, cfg_loop_first};
                if (loops_left > 0)
                    loops_left--;
            end
        end else begin
            cur_seg = cur_seg + 5'd1;
        end
        if (cur_seg == cfg_seg_total)
            cur_seg = 5'd0;
        seg_ticks_left = seg_ticks(cur_seg);
    endfunction

    // advances the predicted state by one transaction and collects its writes
    function automatic void step_sequencer(seg_item_t it);
        tick_writes.delete();
        if (it.cmd == CMD_LOAD) begin
            len_tab[it.idx] = it.len;
            mag_tab[it.idx] = it.mag;
            fs_tab[it.idx] = it.fs;
            cr_tab[it.idx] = it.cr;
            return;
        end
        if (it.trig)
            start_waiting = 1'b1;
        if (!run_active) begin
            if (!start_waiting)
                return;
            start_waiting = 1'b0;
            run_active = 1'b1;
            cur_seg = 5'd1;
            seg_ticks_left = seg_ticks(5'd1);
            loops_left = int'(cfg_loop_count);
        end
        if (cur_seg == 5'd0) begin
            // rest segment closes the run
            run_active = 1'b0;
            apply_seg(5'd0);
            return;
        end
        apply_seg(cur_seg);
        next_segment();
    endfunction

    task automatic write_cfg(sss_pkg::cfg_idx_t idx, logic [31:0] data);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            sss_pkg::REG_STIM_CHANNEL:  cfg_ch = data[3:0];
            sss_pkg::REG_LOOP_FIRST:    cfg_loop_first = data[3:0];
            sss_pkg::REG_LOOP_LAST:     cfg_loop_last = data[3:0];
            sss_pkg::REG_LOOP_COUNT:    cfg_loop_count = data[8:0];
            sss_pkg::REG_SEGMENT_TOTAL: cfg_seg_total = data[4:0];
            sss_pkg::REG_SETTLE_MODE:   cfg_settle_trad = data[0];
            sss_pkg::REG_RECOVERY_MODE: cfg_recov_sw = data[0];
            default: ;
        endcase
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(int ch, int first, int last_seg, int count, int total,
                              int settle, int recov);
        logic [8:0] count9;
        count9 = count[8:0];
        write_cfg(sss_pkg::REG_STIM_CHANNEL, ch);
        write_cfg(sss_pkg::REG_LOOP_FIRST, first);
        write_cfg(sss_pkg::REG_LOOP_LAST, last_seg);
        write_cfg(sss_pkg::REG_LOOP_COUNT, {23'd0, count9});
        write_cfg(sss_pkg::REG_SEGMENT_TOTAL, total);
        write_cfg(sss_pkg::REG_SETTLE_MODE, settle);
        write_cfg(sss_pkg::REG_RECOVERY_MODE, recov);
    endtask

    task automatic add_row(cmd_t cmd, bit trig, int idx, int len, int mag, bit fs, bit cr,
                           int typed_n);
        script_row_t row;
        row.it.cmd = cmd;
        row.it.trig = trig;
        row.it.idx = idx[3:0];
        row.it.len = len[15:0];
        row.it.mag = mag[8:0];
        row.it.fs = fs;
        row.it.cr = cr;
        row.typed_n = typed_n;
        script.push_back(row);
    endtask

    // one transaction on the input channel, then the sender's own pacing
    task automatic send_item(seg_item_t it, int typed_n);
        int gap;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_command <= it.cmd;
        s_trigger <= it.trig;
        s_seg_index <= it.idx;
        s_seg_length <= it.len;
        s_seg_magnitude <= it.mag;
        s_seg_settle <= it.fs;
        s_seg_recovery <= it.cr;
        do @(posedge aclk); while (!s_ready);
        step_sequencer(it);
        if (typed_n < 0) begin
            foreach (tick_writes[i])
                reg_writes_due.push_back(tick_writes[i]);
        end else begin
            repeat (typed_n)
                reg_writes_due.push_back(typed_writes.pop_front());
        end
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_for_writes();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (reg_writes_due.size() != 0)
            @(posedge aclk);
        // ticks that queue no write may still be in flight
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic seg_item_t random_item();
        seg_item_t it;
        int        pick;
        int        mag;
        it.cmd = ($urandom_range(0, 99) < 22) ? CMD_LOAD : CMD_TICK;
        it.trig = ($urandom_range(0, 99) < 15);
        it.idx = 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 19);
        if (pick < 15)
            it.len = 16'($urandom_range(0, 3));
        else if (pick < 19)
            it.len = 16'($urandom_range(4, 15));
        else
            it.len = 16'($urandom_range(16, 40));
        pick = $urandom_range(0, 19);
        if (pick < 4)
            mag = 0;
        else if (pick == 4)
            mag = 255;
        else if (pick == 5)
            mag = -255;
        else
            mag = int'($urandom_range(0, 510)) - 255;
        it.mag = mag[8:0];
        it.fs = 1'($urandom_range(0, 1));
        it.cr = 1'($urandom_range(0, 1));
        return it;
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver stalls follow one of four ready patterns, redrawn at random as the cycle counter advances
    always @(negedge aclk) begin
        if (cycle_count % 64 == 0)
            ready_mode = $urandom_range(0, 3);
        case (ready_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 4) == 0);
            default: m_ready <= (cycle_count % 3 == 0);
        endcase
    end

    always @(posedge aclk) begin : write_check
        reg_write_t want;
        if (aresetn && m_valid && m_ready) begin
            if (reg_writes_due.size() == 0) begin
                $display("%0t unexpected write: expected none, got addr %0d value %0d",
                         $time, m_reg_addr, m_new_value);
                errors++;
            end else begin
                want = reg_writes_due.pop_front();
                if (m_reg_addr !== want.addr) begin
                    $display("%0t reg_addr: expected %0d, got %0d",
                             $time, want.addr, m_reg_addr);
                    errors++;
                end
                if (m_new_value !== want.value) begin
                    $display("%0t new_value: expected %0d, got %0d",
                             $time, want.value, m_new_value);
                    errors++;
                end
                if (m_last_of_tick !== want.last) begin
                    $display("%0t last_of_tick: expected %0d, got %0d",
                             $time, want.last, m_last_of_tick);
                    errors++;
                end
            end
        end
    end

    initial begin
        int        counted;
        int        phase_items;
        int        phase;
        int        pick;
        int        count;
        seg_item_t it;

        // directed script: loads before the first trigger so that no run ever reads an unwritten entry
        add_row(CMD_TICK, 1'b0, 0, 0, 0, 1'b0, 1'b0, 0);           // idle tick, nothing pending
        add_row(CMD_LOAD, 1'b1, 15, 65535, 255, 1'b1, 1'b1, 0);    // trigger ignored on a load
        add_row(CMD_LOAD, 1'b0, 0, 0, 0, 1'b0, 1'b0, 0);
        add_row(CMD_LOAD, 1'b0, 1, 1, 255, 1'b1, 1'b1, 0);
        add_row(CMD_LOAD, 1'b0, 2, 2, -255, 1'b0, 1'b1, 0);
        add_row(CMD_LOAD, 1'b0, 3, 0, -256, 1'b1, 1'b0, 0);        // saturates to 255
        add_row(CMD_LOAD, 1'b0, 4, 3, 0, 1'b1, 1'b1, 0);
        add_row(CMD_LOAD, 1'b0, 5, 1, 100, 1'b0, 1'b0, 0);
        add_row(CMD_LOAD, 1'b0, 6, 2, -1, 1'b1, 1'b0, 0);
        add_row(CMD_LOAD, 1'b0, 7, 1, 1, 1'b0, 1'b1, 0);
        add_row(CMD_LOAD, 1'b0, 8, 4, -128, 1'b0, 1'b0, 0);
        add_row(CMD_LOAD, 1'b0, 9, 1, 127, 1'b1, 1'b1, 0);
        add_row(CMD_LOAD, 1'b0, 10, 2, 0, 1'b0, 1'b0, 0);
        add_row(CMD_LOAD, 1'b0, 11, 1, -37, 1'b0, 1'b1, 0);
        add_row(CMD_LOAD, 1'b0, 12, 3, 55, 1'b1, 1'b0, 0);
        add_row(CMD_LOAD, 1'b0, 13, 1, -200, 1'b0, 1'b0, 0);
        add_row(CMD_LOAD, 1'b0, 14, 2, 17, 1'b1, 1'b1, 0);
        add_row(CMD_LOAD, 1'b0, 15, 1, -90, 1'b1, 1'b1, 0);
        // first applied segment from a clean shadow: every value changes
        add_row(CMD_TICK, 1'b1, 0, 0, 0, 1'b0, 1'b0, 5);
        typed_writes.push_back(reg_write_t'{sss_pkg::ADDR_STIM_ON, 8'd1, 1'b0});
        typed_writes.push_back(reg_write_t'{sss_pkg::ADDR_POS_BASE + 7'd15, 8'd255, 1'b0});
        typed_writes.push_back(reg_write_t'{sss_pkg::ADDR_STIM_POL, 8'd1, 1'b0});
        typed_writes.push_back(reg_write_t'{sss_pkg::ADDR_SETTLE_TRAD, 8'd1, 1'b0});
        typed_writes.push_back(reg_write_t'{sss_pkg::ADDR_RECOV_SW, 8'd1, 1'b1});
        add_row(CMD_TICK, 1'b1, 0, 0, 0, 1'b0, 1'b0, -1);          // trigger while running
        repeat (7)
            add_row(CMD_TICK, 1'b0, 0, 0, 0, 1'b0, 1'b0, -1);

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        set_config(15, 1, 2, 1, 4, 1, 1);
        foreach (script[i])
            send_item(script[i].it, script[i].typed_n);

        counted = 0;
        phase = 0;
        while (counted < RANDOM_ITEMS) begin
            wait_for_writes();
            case (phase)
                0: set_config(0, 0, 0, 0, 0, 0, 0);
                1: set_config(15, 15, 15, 255, 16, 1, 1);
                default: begin
                    pick = $urandom_range(0, 3);
                    if (phase == 2 || pick == 0)
                        count = -1;
                    else if (pick == 1)
                        count = $urandom_range(0, 255);
                    else
                        count = $urandom_range(0, 3);
                    set_config($urandom_range(0, 15), $urandom_range(0, 7),
                               ($urandom_range(0, 1) == 0) ? $urandom_range(0, 7)
                                                           : $urandom_range(0, 15),
                               count, $urandom_range(0, 16),
                               $urandom_range(0, 1), $urandom_range(0, 1));
                end
            endcase
            phase_items = 0;
            while (phase_items < PHASE_ITEMS && counted < RANDOM_ITEMS) begin
                it = random_item();
                send_item(it, -1);
                counted++;
                phase_items++;
            end
            phase++;
        end

        wait_for_writes();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
